/* hdl/thpd_pkg.sv */
// ----------------------------------------------------------------------------
// Timed haptic PWM driver package
// Shared constants and transaction types of the vibration motor driver.
// ----------------------------------------------------------------------------
package thpd_pkg;

  localparam int unsigned PERIOD_TICKS = 100;
  localparam int unsigned MAX_LEVEL    = 50;
  localparam int unsigned TICKS_PER_MS = 1000;
  localparam int unsigned HALF_PERIOD  = PERIOD_TICKS / 2;

  localparam int unsigned REQ_W   = 16;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned CNT_W   = 26;
  localparam int unsigned LEVEL_W = 6;
  localparam int unsigned PHASE_W = 7;

  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  typedef struct packed {
    logic             op;
    logic [REQ_W-1:0] level_request;
    logic [MS_W-1:0]  timeout_ms;
  } item_t;

  typedef struct packed {
    logic             enable_out;
    logic             pwm_out;
    logic [CNT_W-1:0] remaining_us;
  } result_t;

endpackage

/* hdl/thpd_in_stage.sv */
// ----------------------------------------------------------------------------
// Input stage
// Registers one accepted input transaction and holds it until it advances.
// ----------------------------------------------------------------------------
module thpd_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  thpd_pkg::item_t item_i,
  output logic            valid_o,
  input  logic            advance_i,
  output thpd_pkg::item_t item_o
);

  logic            valid_q;
  logic            valid_d;
  thpd_pkg::item_t item_q;

  // The slot frees up in the same cycle its content moves on.
  assign ready_o = !valid_q || advance_i;
  assign valid_d = valid_i || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* hdl/thpd_core.sv */
// ----------------------------------------------------------------------------
// Driver core
// Motor state, PWM phase and countdown; computes one result per transaction.
// ----------------------------------------------------------------------------
module thpd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  thpd_pkg::item_t   item_i,
  output thpd_pkg::result_t result_o
);

  logic                         active_q, active_d;
  logic [thpd_pkg::LEVEL_W-1:0] duty_q, duty_d;
  logic [thpd_pkg::PHASE_W-1:0] phase_q, phase_d;
  logic [thpd_pkg::PHASE_W-1:0] high_q, high_d;
  logic [thpd_pkg::CNT_W-1:0]   count_q, count_d;

  logic [thpd_pkg::LEVEL_W-1:0] clamped_level;
  logic [thpd_pkg::CNT_W-1:0]   new_count;
  logic [thpd_pkg::PHASE_W-1:0] high_now;
  logic                         pwm;

  assign clamped_level =
    (item_i.level_request > thpd_pkg::REQ_W'(thpd_pkg::MAX_LEVEL)) ?
    thpd_pkg::LEVEL_W'(thpd_pkg::MAX_LEVEL) : item_i.level_request[thpd_pkg::LEVEL_W-1:0];

  assign new_count = thpd_pkg::CNT_W'(item_i.timeout_ms) *
                     thpd_pkg::CNT_W'(thpd_pkg::TICKS_PER_MS);

  // The high time is latched at the first tick of every period.
  assign high_now = (phase_q == '0) ?
                    thpd_pkg::PHASE_W'(thpd_pkg::HALF_PERIOD) + thpd_pkg::PHASE_W'(duty_q) :
                    high_q;

  always_comb begin
    active_d = active_q;
    duty_d   = duty_q;
    phase_d  = phase_q;
    high_d   = high_q;
    count_d  = count_q;
    pwm      = 1'b0;
    if (item_i.op == thpd_pkg::OP_COMMAND) begin
      if (item_i.level_request == '0 || new_count == '0) begin
        active_d = 1'b0;
        duty_d   = '0;
        count_d  = '0;
      end else begin
        duty_d   = clamped_level;
        count_d  = new_count;
        active_d = 1'b1;
        if (!active_q) begin
          phase_d = '0;
        end
      end
    end else if (active_q) begin
      high_d  = high_now;
      pwm     = (phase_q < high_now);
      phase_d = (phase_q == thpd_pkg::PHASE_W'(thpd_pkg::PERIOD_TICKS - 1)) ?
                '0 : phase_q + thpd_pkg::PHASE_W'(1);
      count_d = count_q - thpd_pkg::CNT_W'(1);
      if (count_d == '0) begin
        active_d = 1'b0;
        duty_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      duty_q   <= '0;
      phase_q  <= '0;
      high_q   <= thpd_pkg::PHASE_W'(thpd_pkg::HALF_PERIOD);
      count_q  <= '0;
    end else if (step_i) begin
      active_q <= active_d;
      duty_q   <= duty_d;
      phase_q  <= phase_d;
      high_q   <= high_d;
      count_q  <= count_d;
    end
  end

  // A tick shows the pins for its own microsecond; a command shows the new state.
  assign result_o.enable_out   = (item_i.op == thpd_pkg::OP_COMMAND) ? active_d : active_q;
  assign result_o.pwm_out      = pwm;
  assign result_o.remaining_us = count_d;

endmodule

/* hdl/thpd_out_stage.sv */
// ----------------------------------------------------------------------------
// Output stage
// Result register that holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
module thpd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  thpd_pkg::result_t result_i,
  output logic              valid_o,
  input  logic              ready_i,
  output thpd_pkg::result_t result_o
);

  logic              valid_q;
  logic              valid_d;
  thpd_pkg::result_t result_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = valid_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

/* hdl/timed_haptic_pwm_driver_core.sv */
// ----------------------------------------------------------------------------
// Timed haptic PWM driver
// Vibration motor driver with level clamp, millisecond timeout and PWM output.
// ----------------------------------------------------------------------------
// Usage: each input transaction is either a one-microsecond tick (op = 0) or a
// vibration command (op = 1) carrying a level and a duration in milliseconds.
// Every input transaction yields exactly one output transaction with the
// enable pin, the PWM pin and the microseconds left before automatic stop.
// Both channels use valid/ready handshakes.
// Path: an accepted input waits in the input register, the combinational state
// update computes its result, and the result register captures it and presents
// it on the output until the receiver takes it.
// Throughput: one transaction per cycle while out_ready_i is high, set by the
// combinational update between the two registers, so ticks stream at clock rate.
// Reset empties both stage registers and puts the motor in the off state with
// the PWM phase at zero and a high time of half a period.
// When the receiver stalls, the result register holds its value, the input
// register then holds its item, and in_ready_o drops until the result is taken;
// no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module timed_haptic_pwm_driver_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [15:0] level_request_i,
  input  logic [15:0] timeout_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        enable_out_o,
  output logic        pwm_out_o,
  output logic [25:0] remaining_us_o
);

  thpd_pkg::item_t   in_item;
  thpd_pkg::item_t   stage_item;
  thpd_pkg::result_t core_result;
  thpd_pkg::result_t out_result;
  logic              stage_valid;
  logic              out_slot_ready;
  logic              advance;

  assign in_item.op            = op_i;
  assign in_item.level_request = level_request_i;
  assign in_item.timeout_ms    = timeout_ms_i;

  // The held item is processed, and the driver state updated, exactly in the
  // cycle it moves into the result register.
  assign advance = stage_valid && out_slot_ready;

  thpd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .item_i    (in_item),
    .valid_o   (stage_valid),
    .advance_i (advance),
    .item_o    (stage_item)
  );

  thpd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (stage_item),
    .result_o (core_result)
  );

  thpd_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stage_valid),
    .ready_o  (out_slot_ready),
    .result_i (core_result),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .result_o (out_result)
  );

  assign enable_out_o   = out_result.enable_out;
  assign pwm_out_o      = out_result.pwm_out;
  assign remaining_us_o = out_result.remaining_us;

endmodule
